>>> rtl/core/ohl_pkg.sv
// ----------------------------------------------------------------------------
// ohl_pkg: shared types and constants of the open handle LRU limiter
// Table size, field widths, opcode and sequencer state encodings.
// ----------------------------------------------------------------------------
package ohl_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = 4;
	localparam int SCAN_W  = IDX_W + 1;
	localparam int STAMP_W = 64;
	localparam int CNT_W   = 5;
	localparam int OP_W    = 2;

	localparam logic [CNT_W-1:0]  ENTRIES_C  = CNT_W'(ENTRIES);
	localparam logic [SCAN_W-1:0] SCAN_END   = SCAN_W'(ENTRIES);

	typedef enum logic [OP_W-1:0] {
		OP_ACCESS = 2'd0,
		OP_OPEN   = 2'd1,
		OP_CLOSE  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Zero acts as one, anything above the table size acts as the table size.
	function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] lim);
		logic [CNT_W-1:0] res;
		res = lim;
		if (lim == '0) begin
			res = CNT_W'(1);
		end else if (lim > ENTRIES_C) begin
			res = ENTRIES_C;
		end
		return res;
	endfunction

	function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
		return {1'b0, idx} < ENTRIES_C;
	endfunction

endpackage

>>> rtl/core/ohl_ram.sv
// ----------------------------------------------------------------------------
// ohl_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ohl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/open_handle_lru_limiter.sv
// ----------------------------------------------------------------------------
// open_handle_lru_limiter: open table with least recently used eviction
// Tracks open flags and last-access stamps of a fixed table of slots.
// ----------------------------------------------------------------------------
// Each request (opcode, slot) gives one result: eviction flag, evicted slot
// and open count after the request. A request is accepted and then committed;
// an open of a closed slot with the table at its limit first runs a scan over
// all slots through the single read port of the stamp RAM with one 64-bit
// comparator, one slot per cycle. The block takes no new request until the
// current one is committed; a finished result waits in the output register.
// The user must write the limit register through cfg_we/cfg_wdata only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module open_handle_lru_limiter import ohl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] opcode, [5:2] entry_index, [7:6] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] evicted, [4:1] evicted_index,
	                               // [9:5] open_count, [15:10] zero
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata  // open_limit
);

	state_t state_q, state_d;

	logic [OP_W-1:0]    op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   limit_q;
	logic [ENTRIES-1:0] flags_q;
	logic               out_vld_q;
	logic [15:0]        out_data_q;

	logic [OP_W-1:0]    in_op;
	logic [IDX_W-1:0]   in_idx;
	logic               accept;
	logic               in_scan;
	logic               scan_run;
	logic               done_fire;
	logic               cand;
	logic               slot_ok;
	logic               slot_open;
	logic               restamp;
	logic               do_open;
	logic               do_close;
	logic               evict;
	logic [CNT_W-1:0]   count_d;
	logic [ENTRIES-1:0] flags_d;
	logic               ram_we;
	logic [STAMP_W-1:0] ram_rdata;

	assign in_op  = s_tdata[1:0];
	assign in_idx = s_tdata[5:2];
	assign accept = s_tvalid && s_tready;

	assign in_scan = (in_op == OP_OPEN) && idx_ok(in_idx) && !flags_q[in_idx]
		&& (count_q >= eff_limit(limit_q));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = in_scan ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (scan_q == SCAN_END) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (done_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		scan_run  = 1'b0;
		done_fire = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: scan_run = scan_q < SCAN_END;
			ST_DONE: done_fire = !out_vld_q || m_tready;
			default: s_tready = 1'b0;
		endcase
	end

	// Shared comparator: keep the oldest open slot, ties to the lower index
	assign cand = rd_vld_s1 && flags_q[rd_idx_s1] && (!found_q || ram_rdata < best_stamp_q);

	// Commit decode
	assign slot_ok   = idx_ok(idx_q);
	assign slot_open = slot_ok && flags_q[idx_q];
	assign restamp   = slot_open && (op_q == OP_ACCESS || op_q == OP_OPEN);
	assign do_open   = slot_ok && !flags_q[idx_q] && (op_q == OP_OPEN);
	assign do_close  = slot_open && (op_q == OP_CLOSE);
	assign evict     = do_open && found_q;

	always_comb begin
		count_d = count_q;
		if (evict) begin
			count_d = count_d - CNT_W'(1);
		end
		if (do_open) begin
			count_d = count_d + CNT_W'(1);
		end
		if (do_close) begin
			count_d = count_d - CNT_W'(1);
		end
	end

	// drop the victim, then set or clear the requested slot
	always_comb begin
		flags_d = flags_q;
		if (evict) begin
			flags_d[best_idx_q] = 1'b0;
		end
		if (do_open) begin
			flags_d[idx_q] = 1'b1;
		end
		if (do_close) begin
			flags_d[idx_q] = 1'b0;
		end
	end

	assign ram_we = done_fire && (restamp || do_open);

	ohl_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (ENTRIES)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (stamp_q),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			stamp_q   <= '0;
			count_q   <= '0;
			limit_q   <= ENTRIES_C;
			flags_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_run;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (scan_run) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			if (cand) begin
				found_q <= 1'b1;
			end
			if (done_fire) begin
				count_q <= count_d;
				if (ram_we) begin
					stamp_q <= stamp_q + STAMP_W'(1);
				end
				flags_q   <= flags_d;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			idx_q <= in_idx;
		end
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (cand) begin
			best_idx_q   <= rd_idx_s1;
			best_stamp_q <= ram_rdata;
		end
		if (done_fire) begin
			out_data_q <= {6'b0, count_d, (evict ? best_idx_q : IDX_W'(0)), evict};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

>>> rtl/core/ohl_checker.sv
// ----------------------------------------------------------------------------
// ohl_checker: port-level checks of the open handle LRU limiter
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module ohl_checker import ohl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request at a time: no transaction right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:5] <= ENTRIES_C)
		else $error("open count above table size");

	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
		else $error("evicted index set without eviction");

endmodule

bind open_handle_lru_limiter ohl_checker u_ohl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/ohl_lru_checker.sv
// ----------------------------------------------------------------------------
// ohl_lru_checker: result checker for the open handle LRU limiter
// Watches the request, result and limit-write ports, keeps its own copy of the
// open table, and compares every result with the predicted one in order.
// ----------------------------------------------------------------------------
module ohl_lru_checker import ohl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] opcode, [5:2] entry_index, [7:6] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [0] evicted, [4:1] evicted_index,
	                               // [9:5] open_count, [15:10] zero
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output int          evictions
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             evicted;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] count;
	} outcome_t;

	logic               is_open [ENTRIES];
	logic [STAMP_W-1:0] last_use [ENTRIES];
	logic [STAMP_W-1:0] next_stamp;
	logic [CNT_W-1:0]   n_open;
	logic [CNT_W-1:0]   limit_reg;
	outcome_t           outcomes [$];

	function automatic void stamp_slot(input logic [IDX_W-1:0] slot);
		last_use[slot] = next_stamp;
		next_stamp = next_stamp + STAMP_W'(1);
	endfunction

	// Update the table copy for one request and return the result it gives.
	function automatic outcome_t apply_request(input logic [OP_W-1:0] op,
	                                           input logic [IDX_W-1:0] slot);
		outcome_t         res;
		logic [CNT_W-1:0] cap;
		logic             found;
		int               oldest;
		res = '0;
		cap = limit_reg;
		if (cap == '0) begin
			cap = CNT_W'(1);
		end
		if (cap > ENTRIES_C) begin
			cap = ENTRIES_C;
		end
		if (int'(slot) < ENTRIES) begin
			if (op == OP_ACCESS) begin
				if (is_open[slot]) begin
					stamp_slot(slot);
				end
			end else if (op == OP_OPEN) begin
				if (!is_open[slot]) begin
					// at the limit: close the open slot with the oldest stamp
					if (n_open >= cap) begin
						found = 1'b0;
						oldest = 0;
						for (int i = 0; i < ENTRIES; i++) begin
							if (is_open[i] && (!found || last_use[oldest] > last_use[i])) begin
								oldest = i;
								found = 1'b1;
							end
						end
						if (found) begin
							is_open[oldest] = 1'b0;
							if (n_open != '0) begin
								n_open = n_open - CNT_W'(1);
							end
							res.evicted = 1'b1;
							res.slot = IDX_W'(oldest);
						end
					end
					is_open[slot] = 1'b1;
					n_open = n_open + CNT_W'(1);
				end
				stamp_slot(slot);
			end else if (op == OP_CLOSE) begin
				if (is_open[slot]) begin
					is_open[slot] = 1'b0;
					if (n_open != '0) begin
						n_open = n_open - CNT_W'(1);
					end
				end
			end
		end
		res.count = n_open;
		return res;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				is_open[i] = 1'b0;
				last_use[i] = '0;
			end
			next_stamp = '0;
			n_open = '0;
			limit_reg = CNT_W'(16);
			outcomes.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
			evictions = 0;
		end else begin
			// check the result transaction before queuing a new request
			if (m_tvalid && m_tready) begin
				got.evicted = m_tdata[0];
				got.slot = m_tdata[4:1];
				got.count = m_tdata[9:5];
				checked++;
				if (got.evicted) begin
					evictions++;
				end
				if (outcomes.size() == 0) begin
					$display("time %0t: result with none expected, actual %h", $time, got);
					mismatches++;
				end else begin
					want = outcomes.pop_front();
					check_field("evicted", want.evicted, got.evicted);
					check_field("evicted_index", want.slot, got.slot);
					check_field("open_count", want.count, got.count);
				end
			end
			if (s_tvalid && s_tready) begin
				outcomes.push_back(apply_request(s_tdata[1:0], s_tdata[5:2]));
			end
			if (cfg_we) begin
				limit_reg = cfg_wdata;
			end
			outstanding = outcomes.size();
		end
	end

endmodule

>>> sim/open_handle_lru_limiter_test.sv
// ----------------------------------------------------------------------------
// open_handle_lru_limiter_test: testbench of the open handle LRU limiter
// Drives directed and random open, access, close and unused-opcode requests under several
// open limits with random idle cycles on both sides; a checker compares results.
// ----------------------------------------------------------------------------
module open_handle_lru_limiter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ohl_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int              QUIET_LIMIT = 1000;
	localparam int              PHASES      = 11;
	localparam int              PHASE_ITEMS = 150;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [1:0] opcode, [5:2] entry_index, [7:6] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // [0] evicted, [4:1] evicted_index,
	                               // [9:5] open_count, [15:10] zero
	logic        cfg_we    = 1'b0;
	logic [4:0]  cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int checked;
	int evictions;
	int idle_pct     = 16;
	int quiet_cycles = 0;
	int sent         = 0;
	int limits_used  = 0;

	open_handle_lru_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ohl_lru_checker lru_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.evictions   (evictions)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// Abort when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("time %0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("open_handle_lru_limiter_test NOT OK");
			$finish;
		end
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] slot);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, slot, op};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Drain all results, let the block settle, then write the limit.
	task automatic set_limit(input logic [4:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		limits_used++;
	endtask

	initial begin
		logic [OP_W-1:0] op;
		int              pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests that change nothing
		send_request(OP_ACCESS, 4'd0);
		send_request(OP_CLOSE, 4'd3);
		send_request(OP_UNUSED, 4'd15);
		// open, reopen and restamp at both ends of the table
		send_request(OP_OPEN, 4'd0);
		send_request(OP_OPEN, 4'd15);
		send_request(OP_OPEN, 4'd0);
		send_request(OP_ACCESS, 4'd15);
		send_request(OP_ACCESS, 4'd0);
		// limit reached: evict the oldest stamp
		set_limit(5'd2);
		send_request(OP_OPEN, 4'd5);
		send_request(OP_OPEN, 4'd7);
		send_request(OP_ACCESS, 4'd5);
		send_request(OP_OPEN, 4'd9);
		// zero limit acts as one, with the count already above it
		set_limit(5'd0);
		send_request(OP_OPEN, 4'd12);
		send_request(OP_CLOSE, 4'd12);
		send_request(OP_CLOSE, 4'd12);
		send_request(OP_OPEN, 4'd3);
		// limit above the table size
		set_limit(5'd31);
		send_request(OP_OPEN, 4'd1);
		send_request(OP_OPEN, 4'd2);
		send_request(OP_OPEN, 4'd14);
		send_request(OP_ACCESS, 4'd3);
		send_request(OP_CLOSE, 4'd1);
		send_request(OP_OPEN, 4'd10);

		// Opens outweigh closes so the table fills and evictions run often.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_limit(5'd16);
				1: set_limit(5'd1);
				2: set_limit(5'd0);
				3: set_limit(5'd31);
				4: set_limit(5'd17);
				default: set_limit(5'($urandom_range(31)));
			endcase
			idle_pct = (phase == 5) ? 0 : 16;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(99);
				if (pick < 42) begin
					op = OP_OPEN;
				end else if (pick < 70) begin
					op = OP_ACCESS;
				end else if (pick < 93) begin
					op = OP_CLOSE;
				end else begin
					op = OP_UNUSED;
				end
				send_request(op, 4'($urandom_range(ENTRIES - 1)));
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (25) @(posedge clk);
		$display("Sent %0d requests under %0d limit settings; checked %0d results, %0d evictions.",
		         sent, limits_used, checked, evictions);
		if (mismatches == 0 && outstanding == 0) begin
			$display("open_handle_lru_limiter_test OK");
		end else begin
			$display("open_handle_lru_limiter_test NOT OK");
		end
		$finish;
	end

endmodule
